### src/imhl_pkg.sv
// shared types and constants for the indexed max-heap leader unit
package imhl_pkg;

    // fixed field widths of the stream payloads
    localparam int ID_W        = 10;
    localparam int DELTA_W     = 16;
    localparam int LEAD_W      = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_FINAL,
        ST_DONE
    } t_state;

    // one input transaction
    typedef struct packed {
        logic signed [DELTA_W-1:0] score_delta;
        logic [ID_W-1:0]           participant_id;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic signed [LEAD_W-1:0] leader_score;
        logic [ID_W-1:0]          leader_id;
    } t_result;

endpackage

### src/indexed_max_heap_leader_unit.sv
// top level of the indexed max-heap leader unit with stream ports
// Each input transaction adds a signed change to one participant's saturating running
// score, keeps an indexed binary max-heap (highest score first, smaller id on ties) in
// order, and returns one result with the current leader's id and score. After reset the
// unit sweeps its score memory, clearing every entry, before taking the first item.
// An accepted item occupies the heap sequencer until its result is handed on, rising
// or falling one heap level at a time, since each level costs a read through the single
// read port of the heap memory and a pass through the shared ranking compare. The
// sequencer takes no new item while one is in progress. An id at or above
// MAX_PARTICIPANTS leaves the state unchanged. The result sits in an output register,
// so the next item is taken while it waits.
module indexed_max_heap_leader_unit #(
    parameter int MAX_PARTICIPANTS = 1024,
    parameter int SCORE_WIDTH      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // participant_id [9:0], score_delta [25:10], zero fill [31:26]
    input  logic [imhl_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // leader_id [9:0], leader_score [41:10], zero fill [47:42]
    output logic [imhl_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int ITEM_W = $bits(imhl_pkg::t_item);
    localparam int RES_W  = $bits(imhl_pkg::t_result);

    imhl_pkg::t_item   item;
    imhl_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;
    logic              r_out_valid;
    imhl_pkg::t_result r_out;

    // unpack input fields
    assign item = i_s_axis_tdata[ITEM_W-1:0];

    imhl_core #(
        .MAX_PARTICIPANTS (MAX_PARTICIPANTS),
        .SCORE_WIDTH      (SCORE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (o_s_axis_tready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    // pack result transaction
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(imhl_pkg::OUT_TDATA_W - RES_W){1'b0}}, r_out};

endmodule

### src/imhl_rank_cmp.sv
// heap ordering compare: higher key first, smaller id first on ties
module imhl_rank_cmp #(
    parameter int KEY_W = 32,
    parameter int IDX_W = 10
) (
    input  logic signed [KEY_W-1:0] i_a_key,
    input  logic [IDX_W-1:0]        i_a_id,
    input  logic signed [KEY_W-1:0] i_b_key,
    input  logic [IDX_W-1:0]        i_b_id,
    output logic                    o_above
);

    // a ranks above b
    always_comb begin
        if (i_a_key != i_b_key) begin
            o_above = (i_a_key > i_b_key);
        end else begin
            o_above = (i_a_id < i_b_id);
        end
    end

endmodule

### src/imhl_sat_add.sv
// saturating add of a signed score change to a running score
module imhl_sat_add #(
    parameter int SCORE_WIDTH = 32
) (
    input  logic signed [SCORE_WIDTH-1:0]           i_score,
    input  logic signed [imhl_pkg::DELTA_W-1:0]     i_delta,
    output logic signed [SCORE_WIDTH-1:0]           o_sum
);

    logic signed [SCORE_WIDTH:0] sum_ext;

    // one guard bit catches overflow
    assign sum_ext = (SCORE_WIDTH+1)'(i_score) + (SCORE_WIDTH+1)'(i_delta);

    // clamp to the signed range when the guard bit disagrees
    always_comb begin
        if (sum_ext[SCORE_WIDTH] != sum_ext[SCORE_WIDTH-1]) begin
            o_sum = sum_ext[SCORE_WIDTH] ? {1'b1, {(SCORE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(SCORE_WIDTH-1){1'b1}}};
        end else begin
            o_sum = sum_ext[SCORE_WIDTH-1:0];
        end
    end

endmodule

### src/imhl_core.sv
// score tables, heap memory and the sift sequencer
module imhl_core #(
    parameter int MAX_PARTICIPANTS = 1024,
    parameter int SCORE_WIDTH      = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  imhl_pkg::t_item   i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output imhl_pkg::t_result o_res
);

    localparam int IW     = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;
    localparam int CW     = $clog2(MAX_PARTICIPANTS + 1);
    localparam int KW     = SCORE_WIDTH;
    localparam int HW     = IW + KW;
    localparam int SW_    = IW + 2;
    localparam int CMPW   = ((CW > imhl_pkg::ID_W) ? CW : imhl_pkg::ID_W) + 1;
    localparam int EXT_W  = (KW > imhl_pkg::LEAD_W) ? KW : imhl_pkg::LEAD_W;

    // memories: per-participant score with seen flag, heap position, heap slots
    logic [KW:0]   r_score_mem [MAX_PARTICIPANTS];
    logic [IW-1:0] r_pos_mem   [MAX_PARTICIPANTS];
    logic [HW-1:0] r_heap_mem  [MAX_PARTICIPANTS];

    imhl_pkg::t_state r_state, n_state;

    logic [IW-1:0]                     r_clr, n_clr;
    logic [imhl_pkg::ID_W-1:0]         r_id, n_id;
    logic signed [imhl_pkg::DELTA_W-1:0] r_delta, n_delta;
    logic [CW-1:0]                     r_count, n_count;
    logic [IW-1:0]                     r_hole, n_hole;
    logic signed [KW-1:0]              r_mkey, n_mkey;
    logic [IW-1:0]                     r_mid, n_mid;
    logic signed [KW-1:0]              r_bkey, n_bkey;
    logic [IW-1:0]                     r_bid, n_bid;
    logic [IW-1:0]                     r_bslot, n_bslot;
    logic                              r_bmov, n_bmov;
    logic                              r_rvalid, n_rvalid;
    logic signed [KW-1:0]              r_top_key, n_top_key;
    logic [IW-1:0]                     r_top_id, n_top_id;

    logic [KW:0]   r_score_rd;
    logic [IW-1:0] r_pos_rd;
    logic [HW-1:0] r_heap_rd;

    // memory port controls
    logic          score_we;
    logic [IW-1:0] score_waddr;
    logic [KW:0]   score_wdata;
    logic          pos_we;
    logic [IW-1:0] pos_waddr;
    logic [IW-1:0] pos_wdata;
    logic          heap_we;
    logic [IW-1:0] heap_waddr;
    logic [HW-1:0] heap_wdata;
    logic [IW-1:0] heap_raddr;

    // decoded values
    logic                  accept;
    logic                  in_range;
    logic [IW-1:0]         id_addr;
    logic                  old_seen;
    logic signed [KW-1:0]  old_score;
    logic signed [KW-1:0]  new_score;
    logic                  fell;
    logic [IW-1:0]         rd_id;
    logic signed [KW-1:0]  rd_key;
    logic [IW-1:0]         parent;
    logic [SW_-1:0]        left, right, count_ext;
    logic                  left_ok, right_ok;
    logic signed [KW-1:0]  cmp_a_key, cmp_b_key;
    logic [IW-1:0]         cmp_a_id, cmp_b_id;
    logic                  above;
    logic                  take_right;
    logic signed [EXT_W-1:0] top_ext;

    assign accept    = i_item_valid && o_item_ready;
    assign in_range  = (CMPW'(r_id) < CMPW'(MAX_PARTICIPANTS));
    assign id_addr   = IW'(r_id);
    assign old_seen  = r_score_rd[KW];
    assign old_score = r_score_rd[KW-1:0];
    assign fell      = (new_score < old_score);
    assign rd_id     = r_heap_rd[IW-1:0];
    assign rd_key    = r_heap_rd[HW-1:IW];
    assign parent    = (r_hole - IW'(1)) >> 1;
    assign left      = {1'b0, r_hole, 1'b1};
    assign right     = {1'b0, r_hole, 1'b0} + SW_'(2);
    assign count_ext = SW_'(r_count);
    assign left_ok   = (left < count_ext);
    assign right_ok  = (right < count_ext);
    assign take_right = r_rvalid && above;

    // saturating score update
    imhl_sat_add #(
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_sat_add (
        .i_score (old_score),
        .i_delta (r_delta),
        .o_sum   (new_score)
    );

    // shared compare operands, chosen by the sift step
    always_comb begin
        cmp_a_key = r_mkey;
        cmp_a_id  = r_mid;
        cmp_b_key = rd_key;
        cmp_b_id  = rd_id;
        case (r_state)
            imhl_pkg::ST_DN_RDR: begin
                cmp_a_key = rd_key;
                cmp_a_id  = rd_id;
                cmp_b_key = r_mkey;
                cmp_b_id  = r_mid;
            end
            imhl_pkg::ST_DN_CMP: begin
                cmp_a_key = rd_key;
                cmp_a_id  = rd_id;
                cmp_b_key = r_bkey;
                cmp_b_id  = r_bid;
            end
            default: begin
            end
        endcase
    end

    imhl_rank_cmp #(
        .KEY_W (KW),
        .IDX_W (IW)
    ) u_rank_cmp (
        .i_a_key (cmp_a_key),
        .i_a_id  (cmp_a_id),
        .i_b_key (cmp_b_key),
        .i_b_id  (cmp_b_id),
        .o_above (above)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            imhl_pkg::ST_CLEAR: begin
                if (r_clr == IW'(MAX_PARTICIPANTS - 1)) n_state = imhl_pkg::ST_IDLE;
            end
            imhl_pkg::ST_IDLE: begin
                if (accept) n_state = imhl_pkg::ST_LOOKUP;
            end
            imhl_pkg::ST_LOOKUP: begin
                n_state = in_range ? imhl_pkg::ST_UPDATE : imhl_pkg::ST_DONE;
            end
            imhl_pkg::ST_UPDATE: begin
                if (old_seen && fell) n_state = imhl_pkg::ST_DN_RDL;
                else                  n_state = imhl_pkg::ST_UP_RD;
            end
            imhl_pkg::ST_UP_RD: begin
                n_state = (r_hole == '0) ? imhl_pkg::ST_FINAL : imhl_pkg::ST_UP_CMP;
            end
            imhl_pkg::ST_UP_CMP: begin
                n_state = above ? imhl_pkg::ST_UP_RD : imhl_pkg::ST_FINAL;
            end
            imhl_pkg::ST_DN_RDL: begin
                n_state = left_ok ? imhl_pkg::ST_DN_RDR : imhl_pkg::ST_FINAL;
            end
            imhl_pkg::ST_DN_RDR: begin
                n_state = imhl_pkg::ST_DN_CMP;
            end
            imhl_pkg::ST_DN_CMP: begin
                if (take_right || !r_bmov) n_state = imhl_pkg::ST_DN_RDL;
                else                       n_state = imhl_pkg::ST_FINAL;
            end
            imhl_pkg::ST_FINAL: begin
                n_state = imhl_pkg::ST_DONE;
            end
            imhl_pkg::ST_DONE: begin
                if (i_res_ready) n_state = imhl_pkg::ST_IDLE;
            end
            default: begin
                n_state = imhl_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr       = r_clr;
        n_id        = r_id;
        n_delta     = r_delta;
        n_count     = r_count;
        n_hole      = r_hole;
        n_mkey      = r_mkey;
        n_mid       = r_mid;
        n_bkey      = r_bkey;
        n_bid       = r_bid;
        n_bslot     = r_bslot;
        n_bmov      = r_bmov;
        n_rvalid    = r_rvalid;
        score_we    = 1'b0;
        score_waddr = id_addr;
        score_wdata = {1'b1, new_score};
        pos_we      = 1'b0;
        pos_waddr   = r_mid;
        pos_wdata   = r_hole;
        heap_we     = 1'b0;
        heap_waddr  = r_hole;
        heap_wdata  = {r_mkey, r_mid};
        heap_raddr  = r_hole;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        case (r_state)
            imhl_pkg::ST_CLEAR: begin
                score_we    = 1'b1;
                score_waddr = r_clr;
                score_wdata = '0;
                n_clr       = r_clr + IW'(1);
            end
            imhl_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (accept) begin
                    n_id    = i_item.participant_id;
                    n_delta = i_item.score_delta;
                end
            end
            imhl_pkg::ST_UPDATE: begin
                score_we = 1'b1;
                n_mkey   = new_score;
                n_mid    = id_addr;
                if (!old_seen) begin
                    n_hole  = IW'(r_count);
                    n_count = r_count + CW'(1);
                end else begin
                    n_hole = r_pos_rd;
                end
            end
            imhl_pkg::ST_UP_RD: begin
                heap_raddr = parent;
            end
            imhl_pkg::ST_UP_CMP: begin
                // parent moves down into the hole
                if (above) begin
                    heap_we    = 1'b1;
                    heap_wdata = r_heap_rd;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_id;
                    n_hole     = parent;
                end
            end
            imhl_pkg::ST_DN_RDL: begin
                heap_raddr = left[IW-1:0];
            end
            imhl_pkg::ST_DN_RDR: begin
                heap_raddr = right[IW-1:0];
                n_rvalid   = right_ok;
                if (above) begin
                    n_bkey  = rd_key;
                    n_bid   = rd_id;
                    n_bslot = left[IW-1:0];
                    n_bmov  = 1'b0;
                end else begin
                    n_bkey  = r_mkey;
                    n_bid   = r_mid;
                    n_bslot = r_hole;
                    n_bmov  = 1'b1;
                end
            end
            imhl_pkg::ST_DN_CMP: begin
                // best child moves up into the hole
                if (take_right) begin
                    heap_we    = 1'b1;
                    heap_wdata = r_heap_rd;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_id;
                    n_hole     = right[IW-1:0];
                end else if (!r_bmov) begin
                    heap_we    = 1'b1;
                    heap_wdata = {r_bkey, r_bid};
                    pos_we     = 1'b1;
                    pos_waddr  = r_bid;
                    n_hole     = r_bslot;
                end
            end
            imhl_pkg::ST_FINAL: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            imhl_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // heap top mirror follows every write to the root slot
    always_comb begin
        n_top_key = r_top_key;
        n_top_id  = r_top_id;
        if (heap_we && (heap_waddr == '0)) begin
            n_top_key = heap_wdata[HW-1:IW];
            n_top_id  = heap_wdata[IW-1:0];
        end
    end

    // result
    assign top_ext = EXT_W'(r_top_key);
    always_comb begin
        if (r_count == '0) begin
            o_res.leader_id    = '0;
            o_res.leader_score = '0;
        end else begin
            o_res.leader_id    = imhl_pkg::ID_W'(r_top_id);
            o_res.leader_score = top_ext[imhl_pkg::LEAD_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imhl_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_delta   <= n_delta;
        r_hole    <= n_hole;
        r_mkey    <= n_mkey;
        r_mid     <= n_mid;
        r_bkey    <= n_bkey;
        r_bid     <= n_bid;
        r_bslot   <= n_bslot;
        r_bmov    <= n_bmov;
        r_rvalid  <= n_rvalid;
        r_top_key <= n_top_key;
        r_top_id  <= n_top_id;
    end

    // score and seen memory
    always_ff @(posedge i_clk) begin
        if (score_we) r_score_mem[score_waddr] <= score_wdata;
        r_score_rd <= r_score_mem[id_addr];
    end

    // heap position memory
    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos_mem[pos_waddr] <= pos_wdata;
        r_pos_rd <= r_pos_mem[id_addr];
    end

    // heap slot memory
    always_ff @(posedge i_clk) begin
        if (heap_we) r_heap_mem[heap_waddr] <= heap_wdata;
        r_heap_rd <= r_heap_mem[heap_raddr];
    end

    // heap never holds more entries than participants
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PARTICIPANTS))
        else $error("heap count above capacity");

    // heap only grows, one entry at a time
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("heap count changed by other than one");

    // the moving entry's hole stays inside the heap while sifting
    a_hole_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imhl_pkg::ST_UP_RD || r_state == imhl_pkg::ST_UP_CMP ||
         r_state == imhl_pkg::ST_DN_RDL || r_state == imhl_pkg::ST_DN_RDR ||
         r_state == imhl_pkg::ST_DN_CMP || r_state == imhl_pkg::ST_FINAL)
        |-> (CW'(r_hole) < r_count))
        else $error("sift hole outside heap");

endmodule

### tb/sv/tb_indexed_max_heap_leader_unit.sv
// self-checking testbench for the indexed max-heap leader unit
module tb_indexed_max_heap_leader_unit;

    localparam int ID_W        = imhl_pkg::ID_W;
    localparam int DELTA_W     = imhl_pkg::DELTA_W;
    localparam int LEAD_W      = imhl_pkg::LEAD_W;
    localparam int IN_TDATA_W  = imhl_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = imhl_pkg::OUT_TDATA_W;

    localparam int N_PART  = 1024;
    localparam int SCORE_W = 32;
    localparam int IN_FILL = IN_TDATA_W - $bits(imhl_pkg::t_item);
    localparam int TIMEOUT = 100_000_000;

    localparam logic [ID_W-1:0]           ID_MIN    = '0;
    localparam logic [ID_W-1:0]           ID_MAX    = '1;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // percent of cycles the sender idles and the receiver stalls
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned mismatch_count;
    int unsigned updates_sent;
    int unsigned results_checked;
    int unsigned peak_heap_size;

    // leader expected for each update still in flight
    imhl_pkg::t_result leader_q[$];

    // own copy of the leaderboard: running scores and the indexed heap
    longint      run_score [N_PART];
    bit          is_seen   [N_PART];
    int unsigned slot_of   [N_PART];
    int unsigned heap_id   [N_PART];
    longint      heap_key  [N_PART];
    int unsigned heap_size;

    indexed_max_heap_leader_unit #(
        .MAX_PARTICIPANTS(N_PART),
        .SCORE_WIDTH     (SCORE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the unit hangs
    initial begin
        #TIMEOUT;
        $display("timeout: %0d updates sent, %0d results pending", updates_sent,
                 leader_q.size());
        $display("tb_indexed_max_heap_leader_unit failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // slot a belongs above slot b: higher score, then smaller id
    function automatic bit outranks(input int unsigned a, input int unsigned b);
        if (heap_key[a] != heap_key[b])
            return heap_key[a] > heap_key[b];
        return heap_id[a] < heap_id[b];
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        int unsigned tid;
        longint      tkey;
        tid         = heap_id[a];
        tkey        = heap_key[a];
        heap_id[a]  = heap_id[b];
        heap_key[a] = heap_key[b];
        heap_id[b]  = tid;
        heap_key[b] = tkey;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    function automatic void bubble_up(input int unsigned p);
        int unsigned parent;
        while (p > 0) begin
            parent = (p - 1) >> 1;
            if (!outranks(p, parent))
                break;
            swap_slots(p, parent);
            p = parent;
        end
    endfunction

    function automatic void bubble_down(input int unsigned p);
        int unsigned best;
        int unsigned lc;
        int unsigned rc;
        forever begin
            best = p;
            lc   = 2 * p + 1;
            rc   = lc + 1;
            if (lc < heap_size && outranks(lc, best))
                best = lc;
            if (rc < heap_size && outranks(rc, best))
                best = rc;
            if (best == p)
                break;
            swap_slots(p, best);
            p = best;
        end
    endfunction

    // apply one score change and return the leader that follows
    function automatic imhl_pkg::t_result predict_leader(input imhl_pkg::t_item it);
        int unsigned       pid;
        int unsigned       slot;
        longint            d;
        longint            s;
        longint            hi;
        longint            lo;
        longint            old;
        imhl_pkg::t_result res;
        pid = it.participant_id;
        d   = longint'($signed(it.score_delta));
        hi  = (longint'(1) <<< (SCORE_W - 1)) - 1;
        lo  = -hi - 1;
        // ids beyond the table leave everything as it is
        if (pid < N_PART) begin
            s = run_score[pid];
            if (d > 0 && s > hi - d)
                s = hi;
            else if (d < 0 && s < lo - d)
                s = lo;
            else
                s = s + d;
            run_score[pid] = s;
            if (!is_seen[pid]) begin
                // first sighting: append and rise
                slot           = heap_size;
                is_seen[pid]   = 1'b1;
                heap_size++;
                heap_id[slot]  = pid;
                heap_key[slot] = s;
                slot_of[pid]   = slot;
                bubble_up(slot);
            end else begin
                slot = slot_of[pid];
                if (slot < heap_size) begin
                    old            = heap_key[slot];
                    heap_key[slot] = s;
                    if (s < old)
                        bubble_down(slot);
                    else
                        bubble_up(slot);
                end
            end
        end
        if (heap_size > peak_heap_size)
            peak_heap_size = heap_size;
        // empty heap reports id zero, score zero
        if (heap_size == 0) begin
            res = '0;
        end else begin
            res.leader_id    = heap_id[0][ID_W-1:0];
            res.leader_score = heap_key[0][LEAD_W-1:0];
        end
        return res;
    endfunction

    // drive one update transaction, entered and left just after a falling edge
    task automatic send_update(input logic [ID_W-1:0] pid,
                               input logic signed [DELTA_W-1:0] delta);
        imhl_pkg::t_item it;
        it.participant_id = pid;
        it.score_delta    = delta;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{IN_FILL{1'b0}}, it};
        do @(posedge i_clk); while (!o_s_axis_tready);
        leader_q.push_back(predict_leader(it));
        updates_sent++;
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transaction with the oldest expected leader
    always @(posedge i_clk) begin : result_check
        imhl_pkg::t_result got;
        imhl_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(imhl_pkg::t_result)-1:0];
            if (leader_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result id %0d score %0d",
                                          got.leader_id, got.leader_score));
            end else begin
                want = leader_q.pop_front();
                results_checked++;
                if (got.leader_id != want.leader_id)
                    report_mismatch($sformatf("result %0d leader_id %0d, want %0d",
                                              results_checked, got.leader_id,
                                              want.leader_id));
                if (got.leader_score != want.leader_score)
                    report_mismatch($sformatf("result %0d leader_score %0d, want %0d",
                                              results_checked, got.leader_score,
                                              want.leader_score));
                if (o_m_axis_tdata[OUT_TDATA_W-1:$bits(imhl_pkg::t_result)] != '0)
                    report_mismatch($sformatf("result %0d nonzero fill bits %h",
                                              results_checked, o_m_axis_tdata));
            end
        end
    end

    // field extremes, falls and rises, and tie breaks on the smaller id
    // note: with 1024 participants every 10-bit id is valid, so the ignored-id
    // path and the empty-heap report cannot be reached at this configuration
    task automatic test_extremes_and_ties();
        send_update(ID_MIN, '0);
        send_update(ID_MAX, DELTA_MAX);
        send_update(ID_MAX, DELTA_MIN);
        send_update(10'd512, DELTA_MIN);
        send_update(10'd10, 16'sd500);
        send_update(10'd4, 16'sd500);
        send_update(10'd4, -16'sd1);
        send_update(10'd4, 16'sd1);
        send_update(10'd10, '0);
        send_update(10'h2AA, 16'sh5555);
        send_update(10'h155, 16'shAAAA);
        send_update(10'h2AA, 16'shAAAA);
        send_update(10'd512, DELTA_MAX);
        send_update(ID_MIN, DELTA_MAX);
        send_update(10'd4, DELTA_MIN);
        send_update(10'd10, DELTA_MIN);
        send_update(10'h155, 16'sh5555);
        send_update(ID_MAX, DELTA_MAX);
    endtask

    // run one participant far up and another far down with full-scale steps
    task automatic test_full_scale_steps();
        for (int i = 0; i < 200; i++)
            send_update(10'd700, DELTA_MAX);
        send_update(10'd700, -16'sd1);
        send_update(10'd700, 16'sd2);
        for (int i = 0; i < 200; i++)
            send_update(10'd701, DELTA_MIN);
        send_update(10'd701, 16'sd1);
        send_update(10'd701, -16'sd2);
        send_update(10'd700, DELTA_MIN);
    endtask

    // random updates mixing a hot set, a warm set and the whole id range
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
        logic [ID_W-1:0]           pid;
        logic signed [DELTA_W-1:0] delta;
        int unsigned               pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40)
                pid = ID_W'($urandom_range(15));
            else if (pick < 65)
                pid = ID_W'($urandom_range(127));
            else
                pid = ID_W'($urandom);
            pick = $urandom_range(99);
            // coarse small steps make ties common
            if (pick < 40)
                delta = DELTA_W'(int'($urandom_range(6)) * 64 - 192);
            else if (pick < 55)
                delta = ($urandom_range(1) != 0) ? DELTA_MAX : DELTA_MIN;
            else if (pick < 60)
                delta = '0;
            else
                delta = DELTA_W'($urandom);
            send_update(pid, delta);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        updates_sent    = 0;
        results_checked = 0;
        peak_heap_size  = 0;
        heap_size       = 0;
        for (int i = 0; i < N_PART; i++) begin
            run_score[i] = 0;
            is_seen[i]   = 1'b0;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes_and_ties();
        test_full_scale_steps();
        test_random_traffic(0, 0, 310);
        test_random_traffic(63, 0, 310);
        test_random_traffic(0, 63, 310);
        test_random_traffic(7, 7, 310);
        i_s_axis_tvalid <= 1'b0;

        // drain, then give the sequencer time to show any stray result
        while (leader_q.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("sent %0d score updates incl. full-scale steps and tie breaks",
                 updates_sent);
        $display("checked %0d leader results, heap grew to %0d entries",
                 results_checked, peak_heap_size);
        if (mismatch_count == 0) begin
            $display("tb_indexed_max_heap_leader_unit passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_indexed_max_heap_leader_unit failed");
        end
        $finish;
    end

endmodule
